@@ design/n_queens_solution_enumerator_unit_defines.svh @@
// Assertion helpers for the N-queens enumerator.
// Every check samples on the rising edge of clk and is off while rst_n is low.
`ifndef N_QUEENS_SOLUTION_ENUMERATOR_UNIT_DEFINES_SVH
`define N_QUEENS_SOLUTION_ENUMERATOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define NQSE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define NQSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/nqse_pkg.sv @@
`default_nettype none

package nqse_pkg;

    // Default largest board and the board size after reset
    localparam int MAX_BOARD_DEF    = 16;
    localparam int BOARD_SIZE_RESET = 8;

    // Fixed field widths
    localparam int SIZE_W    = 5;
    localparam int OUT_IDX_W = 4;

endpackage

`default_nettype wire

@@ design/nqse_if.sv @@
`default_nettype none

// Request channel: one transaction asks for the next solution
interface nqse_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// Result channel: one transaction per board row, or one exhausted marker
interface nqse_res_if;
    logic                           valid;
    logic                           ready;
    logic [nqse_pkg::OUT_IDX_W-1:0] row_index;
    logic [nqse_pkg::OUT_IDX_W-1:0] queen_column;
    logic                           last_of_solution;
    logic                           exhausted;

    modport source (output valid, output row_index, output queen_column,
                    output last_of_solution, output exhausted, input ready);
    modport sink   (input valid, input row_index, input queen_column,
                    input last_of_solution, input exhausted, output ready);
endinterface

`default_nettype wire

@@ design/nqse_clash_unit.sv @@
`default_nettype none

// Conflict check of one candidate column against the queen of one earlier row.
// Clash when both share a column or the column distance equals the row distance.
module nqse_clash_unit #(
    parameter int  MAX_BOARD = nqse_pkg::MAX_BOARD_DEF,
    localparam int RW        = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1,
    localparam int NW        = $clog2(MAX_BOARD + 1)
) (
    input  wire logic [RW-1:0] placed_col,
    input  wire logic [NW-1:0] cand_col,
    input  wire logic [RW-1:0] cand_row,
    input  wire logic [RW-1:0] placed_row,
    output      logic          clash
);
    logic [NW-1:0] col_ext;
    logic [NW-1:0] col_dist;
    logic [RW-1:0] row_dist;

    // Absolute column distance
    assign col_ext  = NW'(placed_col);
    assign col_dist = (col_ext >= cand_col) ? (col_ext - cand_col) : (cand_col - col_ext);

    // Earlier row always lies above the candidate row
    assign row_dist = cand_row - placed_row;

    assign clash = (col_dist == '0) || (col_dist == NW'(row_dist));

endmodule

`default_nettype wire

@@ design/n_queens_solution_enumerator_unit.sv @@
// N-queens solution enumerator.
// req channel: each transaction asks for the next solution; restart=1 first
//   clears the placement and begins again from an empty board.
// res channel: a solution comes out as board_size transactions, rows 0..n-1
//   in order, last_of_solution on row n-1. When no solution remains a single
//   transaction with exhausted=1, last_of_solution=1, row and column 0 is sent.
// Config: cfg_wr_en/cfg_wr_data write board_size (0 acts as 1, values above
//   MAX_BOARD act as MAX_BOARD) and clear the search. Write only while idle.
// Timing: one conflict check per cycle through a single compare unit. A row
//   visit first fetches its start column, then checks each candidate against
//   the earlier rows in turn, and running past the last column backtracks.
//   The rows of a solution are unloaded after the search places its last
//   row, so the time to an answer follows the search length. An exhausted
//   answer after a finished search is sent without searching again.
// req.ready is high only while the sequencer is idle and no config write is
//   presented; one request in flight.
// A stalled receiver holds the result register and pauses the row unload;
//   the next request may be taken while the last row still waits.
// Reset: board_size becomes 8, placement empty, first request starts fresh.
`default_nettype none
`include "n_queens_solution_enumerator_unit_defines.svh"

module n_queens_solution_enumerator_unit #(
    parameter int MAX_BOARD = nqse_pkg::MAX_BOARD_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [nqse_pkg::SIZE_W-1:0] cfg_wr_data,
    nqse_req_if.sink                         req,
    nqse_res_if.source                       res
);
    localparam int RW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam int NW = $clog2(MAX_BOARD + 1);
    localparam int OW = nqse_pkg::OUT_IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_EMIT,
        ST_EXH
    } state_t;

    state_t                        state_reg, state_next;
    logic [nqse_pkg::SIZE_W-1:0]   bsize_reg, bsize_next;
    logic [MAX_BOARD-1:0]          valid_reg, valid_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic [RW-1:0]                 chk_reg, chk_next;
    logic [NW-1:0]                 cand_reg, cand_next;
    logic [RW-1:0]                 out_idx_reg, out_idx_next;
    logic                          done_reg, done_next;
    logic                          res_valid_reg, res_valid_next;
    logic [OW-1:0]                 res_row_reg, res_row_next;
    logic [OW-1:0]                 res_col_reg, res_col_next;
    logic                          res_last_reg, res_last_next;
    logic                          res_exh_reg, res_exh_next;

    // Placement store, one column per row
    logic [RW-1:0]                 col_mem [MAX_BOARD];
    logic                          col_we;
    logic [RW-1:0]                 rd_addr_next;
    logic [RW-1:0]                 rd_col_reg;

    logic [5:0]                    bsize_ext;
    logic [5:0]                    n_clamp;
    logic [NW-1:0]                 n_act;
    logic                          clash;
    logic                          out_free;
    logic                          clr;

    // Active board size
    assign bsize_ext = 6'(bsize_reg);
    always_comb
    begin
        if (bsize_ext == '0)
            n_clamp = 6'd1;
        else if (bsize_ext > 6'(MAX_BOARD))
            n_clamp = 6'(MAX_BOARD);
        else
            n_clamp = bsize_ext;
    end
    assign n_act = NW'(n_clamp);

    // Read address of the placement store for the coming cycle
    always_comb
    begin
        case (state_next)
            ST_START: rd_addr_next = row_next;
            ST_CHECK: rd_addr_next = chk_next;
            ST_EMIT:  rd_addr_next = out_idx_next;
            default:  rd_addr_next = row_next;
        endcase
    end

    // Shared conflict checker
    nqse_clash_unit #(
        .MAX_BOARD (MAX_BOARD)
    ) u_clash (
        .placed_col (rd_col_reg),
        .cand_col   (cand_reg),
        .cand_row   (row_reg),
        .placed_row (chk_reg),
        .clash      (clash)
    );

    assign out_free  = !res_valid_reg || res.ready;
    assign req.ready = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign clr       = req.restart || (NW'(row_reg) >= n_act);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        bsize_next     = bsize_reg;
        valid_next     = valid_reg;
        row_next       = row_reg;
        chk_next       = chk_reg;
        cand_next      = cand_reg;
        out_idx_next   = out_idx_reg;
        done_next      = done_reg;
        res_valid_next = res_valid_reg;
        res_row_next   = res_row_reg;
        res_col_next   = res_col_reg;
        res_last_next  = res_last_reg;
        res_exh_next   = res_exh_reg;
        col_we         = 1'b0;

        if (res_valid_reg && res.ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    bsize_next = cfg_wr_data;
                    valid_next = '0;
                    row_next   = '0;
                    done_next  = 1'b0;
                end
                else if (req.valid)
                begin
                    if (clr)
                    begin
                        valid_next = '0;
                        row_next   = '0;
                        done_next  = 1'b0;
                    end
                    if (done_reg && !clr)
                        state_next = ST_EXH;
                    else
                        state_next = ST_START;
                end
            end

            // Resume above the stored column, or from column 0
            ST_START:
            begin
                cand_next  = valid_reg[row_reg] ? (NW'(rd_col_reg) + NW'(1)) : '0;
                chk_next   = '0;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (cand_reg >= n_act)
                begin
                    // Row has no legal column: backtrack
                    valid_next[row_reg] = 1'b0;
                    if (row_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_EXH;
                    end
                    else
                    begin
                        row_next   = row_reg - RW'(1);
                        state_next = ST_START;
                    end
                end
                else if (chk_reg == row_reg)
                begin
                    // No earlier row clashes: place the queen
                    col_we              = 1'b1;
                    valid_next[row_reg] = 1'b1;
                    if (NW'(row_reg) == n_act - NW'(1))
                    begin
                        out_idx_next = '0;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        row_next   = row_reg + RW'(1);
                        state_next = ST_START;
                    end
                end
                else if (clash)
                begin
                    cand_next = cand_reg + NW'(1);
                    chk_next  = '0;
                end
                else
                begin
                    chk_next = chk_reg + RW'(1);
                end
            end

            // Unload one row per free output slot
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_row_next   = OW'(out_idx_reg);
                    res_col_next   = OW'(rd_col_reg);
                    res_exh_next   = 1'b0;
                    res_last_next  = (NW'(out_idx_reg) == n_act - NW'(1));
                    if (NW'(out_idx_reg) == n_act - NW'(1))
                        state_next = ST_IDLE;
                    else
                        out_idx_next = out_idx_reg + RW'(1);
                end
            end

            ST_EXH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_row_next   = '0;
                    res_col_next   = '0;
                    res_last_next  = 1'b1;
                    res_exh_next   = 1'b1;
                    row_next       = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bsize_reg     <= nqse_pkg::SIZE_W'(nqse_pkg::BOARD_SIZE_RESET);
            valid_reg     <= '0;
            row_reg       <= '0;
            chk_reg       <= '0;
            cand_reg      <= '0;
            out_idx_reg   <= '0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            res_row_reg   <= '0;
            res_col_reg   <= '0;
            res_last_reg  <= 1'b0;
            res_exh_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bsize_reg     <= bsize_next;
            valid_reg     <= valid_next;
            row_reg       <= row_next;
            chk_reg       <= chk_next;
            cand_reg      <= cand_next;
            out_idx_reg   <= out_idx_next;
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
            res_row_reg   <= res_row_next;
            res_col_reg   <= res_col_next;
            res_last_reg  <= res_last_next;
            res_exh_reg   <= res_exh_next;
        end
    end

    // Placement store: write on placement, registered read, same-edge bypass
    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[row_reg] <= RW'(cand_reg);
        if (col_we && (rd_addr_next == row_reg))
            rd_col_reg <= RW'(cand_reg);
        else
            rd_col_reg <= col_mem[rd_addr_next];
    end

    assign res.valid            = res_valid_reg;
    assign res.row_index        = res_row_reg;
    assign res.queen_column     = res_col_reg;
    assign res.last_of_solution = res_last_reg;
    assign res.exhausted        = res_exh_reg;

    // Checks
    `NQSE_ASSERT_IMPLY(a_row_in_range, state_reg != ST_IDLE, NW'(row_reg) < n_act,
                       "search row beyond board")
    `NQSE_ASSERT_IMPLY(a_emit_placed, state_reg == ST_EMIT, valid_reg[out_idx_reg],
                       "unloading an empty row")
    `NQSE_ASSERT_IMPLY(a_exh_format, res.valid && res.exhausted,
                       res.last_of_solution && (res.row_index == '0)
                       && (res.queen_column == '0),
                       "bad exhausted transaction")
    `NQSE_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready && !cfg_wr_en, !req.ready,
                      "ready right after a request")

endmodule

`default_nettype wire

@@ verif/nqse_solution_checker.sv @@
module nqse_solution_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [nqse_pkg::SIZE_W-1:0] cfg_wr_data,
    nqse_req_if                         req,
    nqse_res_if                         res,
    output int                          error_count,
    output int                          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOARD_MAX = nqse_pkg::MAX_BOARD_DEF;

    // One row of a solution, or the exhausted marker
    typedef struct packed {
        logic [nqse_pkg::OUT_IDX_W-1:0] row;
        logic [nqse_pkg::OUT_IDX_W-1:0] col;
        logic                           last;
        logic                           exh;
    } queen_row_t;

    // Search state kept alongside the block
    logic [nqse_pkg::SIZE_W-1:0] board_reg;
    logic [4:0]                  col_of [BOARD_MAX];
    logic                        col_set [BOARD_MAX];
    logic [3:0]                  resume_row;
    logic                        all_given;

    queen_row_t expected_rows[$];
    int         mismatches = 0;

    assign error_count = mismatches;

    function automatic int board_n();
        if (board_reg == 0)
        begin
            return 1;
        end
        if (int'(board_reg) > BOARD_MAX)
        begin
            return BOARD_MAX;
        end
        return int'(board_reg);
    endfunction

    function automatic void clear_placement();
        for (int i = 0; i < BOARD_MAX; i++)
        begin
            col_of[i]  = '0;
            col_set[i] = 1'b0;
        end
        resume_row = '0;
        all_given  = 1'b0;
    endfunction

    // Lowest column above the stored one that no earlier queen attacks; n if none
    function automatic int lowest_free_column(int n, int row);
        int  first;
        int  d;
        bit  clash;
        first = col_set[row] ? int'(col_of[row]) + 1 : 0;
        for (int j = first; j < n; j++)
        begin
            clash = 1'b0;
            for (int i = 0; i < row; i++)
            begin
                d = int'(col_of[i]) - j;
                if (d == 0 || d == row - i || d == i - row)
                begin
                    clash = 1'b1;
                end
            end
            if (!clash)
            begin
                return j;
            end
        end
        return n;
    endfunction

    // Resume the depth-first search and queue the rows of the next solution
    function automatic void queue_next_solution(logic restart);
        int n;
        int row;
        int c;
        bit found;
        queen_row_t item;
        n = board_n();
        if (restart || int'(resume_row) >= n)
        begin
            clear_placement();
        end
        found = 1'b0;
        if (!all_given)
        begin
            row = int'(resume_row);
            while (!found && !all_given)
            begin
                c = lowest_free_column(n, row);
                if (c >= n)
                begin
                    col_set[row] = 1'b0;
                    if (row == 0)
                    begin
                        all_given = 1'b1;
                    end
                    else
                    begin
                        row--;
                    end
                end
                else
                begin
                    col_of[row]  = 5'(c);
                    col_set[row] = 1'b1;
                    if (row == n - 1)
                    begin
                        resume_row = 4'(row);
                        found      = 1'b1;
                    end
                    else
                    begin
                        row++;
                    end
                end
            end
            if (!found)
            begin
                resume_row = '0;
            end
        end
        if (found)
        begin
            for (int i = 0; i < n; i++)
            begin
                item.row  = 4'(i);
                item.col  = col_of[i][3:0];
                item.last = (i == n - 1);
                item.exh  = 1'b0;
                expected_rows = {expected_rows, item};
            end
        end
        else
        begin
            item = '{row: '0, col: '0, last: 1'b1, exh: 1'b1};
            expected_rows = {expected_rows, item};
        end
    endfunction

    // Track config and requests, check each result transaction in order
    always @(posedge clk or negedge rst_n)
    begin
        queen_row_t got;
        queen_row_t want;
        if (!rst_n)
        begin
            board_reg = nqse_pkg::SIZE_W'(nqse_pkg::BOARD_SIZE_RESET);
            clear_placement();
            expected_rows.delete();
            pending_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                board_reg = cfg_wr_data;
                clear_placement();
            end
            if (req.valid && req.ready)
            begin
                queue_next_solution(req.restart);
            end
            if (res.valid && res.ready)
            begin
                got = '{row: res.row_index, col: res.queen_column,
                        last: res.last_of_solution, exh: res.exhausted};
                if (expected_rows.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: row %0d col %0d last %0b exh %0b",
                             $time, got.row, got.col, got.last, got.exh);
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: mismatch: expected row %0d col %0d last %0b exh %0b,",
                                 $time, want.row, want.col, want.last, want.exh);
                        $display("%0t:           actual   row %0d col %0d last %0b exh %0b",
                                 $time, got.row, got.col, got.last, got.exh);
                    end
                end
            end
            pending_count <= expected_rows.size();
        end
    end

endmodule

@@ verif/n_queens_solution_enumerator_unit_tb.sv @@
module n_queens_solution_enumerator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 280;
    localparam int HOLD_CYCLES  = 500;
    localparam int CYCLE_LIMIT  = 3000000;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [nqse_pkg::SIZE_W-1:0] cfg_wr_data;

    nqse_req_if req_ch ();
    nqse_res_if res_ch ();

    int errs;
    int pending;
    int items_sent = 0;
    int cycle_count = 0;

    // Sink and source behavior, changed per phase by the stimulus
    bit sink_idles   = 1'b1;
    bit src_idles    = 1'b1;
    bit hold_results = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    n_queens_solution_enumerator_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .res         (res_ch)
    );

    nqse_solution_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req           (req_ch),
        .res           (res_ch),
        .error_count   (errs),
        .pending_count (pending)
    );

    // Run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("n_queens_solution_enumerator_unit_tb: errors");
            $finish;
        end
    end

    // Result sink: random ready, steady stretches, one long hold on request
    initial
    begin
        int span;
        forever
        begin
            if (hold_results)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (!sink_idles)
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                res_ch.ready <= ($urandom_range(0, 99) < 65);
                span = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 4)
                                                    : $urandom_range(15, 70);
                repeat (span) @(posedge clk);
            end
        end
    end

    // Offer one request transaction, then an optional gap
    task automatic send_request(input logic restart);
        int r;
        int gap;
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        items_sent++;
        if (src_idles)
        begin
            r   = $urandom_range(0, 99);
            gap = (r < 65) ? 0 : ((r < 94) ? $urandom_range(1, 4) : $urandom_range(20, 90));
            if (gap > 0)
            begin
                req_ch.valid   <= 1'b0;
                req_ch.restart <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering and wait until every queued result row has been seen
    task automatic wait_drained();
        req_ch.valid   <= 1'b0;
        req_ch.restart <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_board(input logic [nqse_pkg::SIZE_W-1:0] size);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [nqse_pkg::SIZE_W-1:0] pick_board();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            return '0;
        end
        if (r < 40)
        begin
            return 5'($urandom_range(1, 6));
        end
        if (r < 80)
        begin
            return 5'($urandom_range(7, 8));
        end
        if (r < 97)
        begin
            return 5'($urandom_range(9, 10));
        end
        return 5'd12;
    endfunction

    function automatic int solution_total(int n);
        case (n)
            6:       return 4;
            7:       return 40;
            default: return 92;
        endcase
    endfunction

    initial
    begin
        int phase;
        int count;
        int n;
        int base;
        logic [nqse_pkg::SIZE_W-1:0] size;

        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.restart <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default 8x8 board: first request after reset starts fresh either way
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);

        // 1x1: one solution, then exhausted and exhausted again, restart brings it back
        write_board(5'd1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);

        // Zero acts as one; boards with no solution at all
        write_board(5'd0);
        send_request(1'b0);
        write_board(5'd2);
        send_request(1'b1);
        write_board(5'd3);
        send_request(1'b0);

        // 4x4: both solutions, exhausted, restart
        write_board(5'd4);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);

        // Largest sizes take far too long to search here: written, then replaced
        write_board(5'd16);
        write_board(5'd31);

        // A write clears the search just as a restart does
        write_board(5'd6);
        send_request(1'b0);
        send_request(1'b0);
        write_board(5'd6);
        send_request(1'b0);

        // Random phases: board size, request run length, idling and pressure
        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            src_idles  = ($urandom_range(0, 3) != 0);
            sink_idles = ($urandom_range(0, 3) != 0);

            if (phase % 4 == 1)
            begin
                // Full sweep to exhaustion and beyond
                n = (phase == 1) ? 7 : $urandom_range(6, 8);
                write_board(5'(n));
                count = solution_total(n) + $urandom_range(1, 3);
                send_request(1'($urandom_range(0, 1)));
                for (int k = 1; k < count; k++)
                begin
                    send_request(1'b0);
                end
            end
            else
            begin
                size = pick_board();
                write_board(size);
                if (size <= 6)
                begin
                    count = $urandom_range(1, 14);
                end
                else if (size <= 8)
                begin
                    count = $urandom_range(3, 30);
                end
                else if (size <= 10)
                begin
                    count = $urandom_range(1, 6);
                end
                else
                begin
                    count = $urandom_range(1, 3);
                end
                if (phase == 2 || phase == 10)
                begin
                    // Long receiver hold while requests keep coming
                    if (count < 6)
                    begin
                        count = 6;
                    end
                    hold_results = 1'b1;
                end
                for (int k = 0; k < count; k++)
                begin
                    if ((phase == 3 && k == count / 2) || $urandom_range(0, 49) == 0)
                    begin
                        wait_drained();
                    end
                    send_request(1'($urandom_range(0, 9) == 0));
                end
            end
            phase++;
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (errs == 0)
        begin
            $display("n_queens_solution_enumerator_unit_tb: clean");
        end
        else
        begin
            $display("n_queens_solution_enumerator_unit_tb: errors");
        end
        $finish;
    end

endmodule
